[design/tsr_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tsr_pkg
// Shared types, constants and lookup functions of the two-player rating update
// ---------------------------------------------------------------------------
package tsr_pkg;

  // default player table depth
  localparam int unsigned DEF_PLAYERS = 1024;

  // fixed point format of ratings and variances
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned TAB_SHIFT  = FRAC_BITS - 2;

  // widths of the shared iterative unit
  localparam int unsigned OPA_W      = 56;
  localparam int unsigned OPB_W      = 34;
  localparam int unsigned DIV_STEPS  = OPA_W;
  localparam int unsigned SQRT_STEPS = OPA_W / 2;

  // numeric limits
  localparam logic [30:0] VAR_MAX    = 31'h7FFF_FFFF;
  localparam logic [16:0] PROB_ONE   = 17'd65536;
  localparam logic [16:0] Q_ONE      = 17'd65536;
  localparam logic [22:0] DELTA_CAP  = 23'h40_0000;
  localparam logic signed [24:0] RATIO_LO = -25'sd327680;
  localparam logic signed [24:0] RATIO_HI = 25'sd327680;

  // Phi table, Q1.16, steps of 1/4 on [0,5]
  localparam logic [16:0] PHI_TAB [0:20] = '{
    17'd32768, 17'd39237, 17'd45316, 17'd50684, 17'd55138, 17'd58612, 17'd61158,
    17'd62911, 17'd64045, 17'd64735, 17'd65129, 17'd65341, 17'd65448, 17'd65498,
    17'd65521, 17'd65530, 17'd65534, 17'd65535, 17'd65536, 17'd65536, 17'd65536
  };

  // N/Phi table, Q16, steps of 1/4 on [-5,5]
  localparam logic [18:0] RATIO_TAB [0:40] = '{
    19'd339909, 19'd324089, 19'd308301, 19'd292540, 19'd276929, 19'd261351,
    19'd245852, 19'd230451, 19'd215161, 19'd199996, 19'd184988, 19'd170171,
    19'd155530, 19'd141148, 19'd127053, 19'd113299, 19'd99952,  19'd87083,
    19'd74782,  19'd63147,  19'd52290,  19'd42326,  19'd33368,  19'd25518,
    19'd18848,  19'd13384,  19'd9096,   19'd5890,   19'd3621,   19'd2106,
    19'd1156,   19'd598,    19'd291,    19'd133,    19'd57,     19'd23,
    19'd9,      19'd3,      19'd1,      19'd0,      19'd0
  };

  // operation codes
  typedef enum logic [1:0] {
    OP_PREDICT = 2'd0,
    OP_GAME    = 2'd1,
    OP_CLEAR   = 2'd2
  } op_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_BETA_SQ  = 2'd0,
    CFG_INIT_VAR = 2'd1,
    CFG_ADD_VAR  = 2'd2
  } cfg_idx_e;

  // shared unit mode
  typedef enum logic {
    MODE_DIV  = 1'b0,
    MODE_SQRT = 1'b1
  } unit_mode_e;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE, ST_RD_B, ST_RD_W, ST_FETCH,
    ST_PR_GO, ST_PR_WT, ST_PD_GO, ST_PD_WT, ST_PROB,
    ST_GR_GO, ST_GR_WT, ST_GX_GO, ST_GX_WT, ST_GV, ST_GRATIO, ST_GWM, ST_GWC,
    ST_MM, ST_MD_GO, ST_MD_WT, ST_MS,
    ST_VM, ST_VD_GO, ST_VD_WT, ST_VF, ST_VS,
    ST_WR_WIN, ST_WR_LOS, ST_DONE
  } state_e;

  // request to the shared divide / square root unit
  typedef struct packed {
    logic             start;
    unit_mode_e       mode;
    logic [OPA_W-1:0] opa;
    logic [OPB_W-1:0] opb;
  } unit_req_t;

  // one player entry of the store
  typedef struct packed {
    logic               valid;
    logic signed [31:0] mean;
    logic [30:0]        spread;
  } entry_t;

  // player index reduced modulo the table depth, by conditional subtraction
  function automatic logic [9:0] idx_mod(input logic [9:0] a, input int unsigned m);
    logic [25:0] r;
    r = 26'(a);
    for (int k = 9; k >= 0; k--) begin
      if (r >= (26'(m) << k)) begin
        r = r - (26'(m) << k);
      end
    end
    return r[9:0];
  endfunction

  // Phi of a nonnegative delta magnitude, interpolated
  function automatic logic [16:0] phi_q16(input logic [22:0] mag);
    logic [8:0]  idx;
    logic [13:0] frac;
    logic [16:0] lo_v;
    logic [16:0] hi_v;
    logic [30:0] prod;
    logic [16:0] r;
    idx  = mag[22:TAB_SHIFT];
    frac = mag[TAB_SHIFT-1:0];
    if (idx >= 9'd20) begin
      r = PROB_ONE;
    end else begin
      lo_v = PHI_TAB[idx[4:0]];
      hi_v = PHI_TAB[idx[4:0] + 5'd1];
      prod = 31'(hi_v - lo_v) * 31'(frac);
      r    = lo_v + 17'(prod >> TAB_SHIFT);
    end
    return r;
  endfunction

  // N/Phi ratio of a signed delta, interpolated, linear tail below -5
  function automatic logic [22:0] gauss_ratio(input logic signed [23:0] x);
    logic signed [24:0] xe;
    logic signed [24:0] d;
    logic [5:0]         i;
    logic [13:0]        fr;
    logic [18:0]        a;
    logic [18:0]        b;
    logic [32:0]        prod;
    logic [22:0]        r;
    xe = {x[23], x};
    d  = xe - RATIO_LO;
    i  = d[19:TAB_SHIFT];
    fr = d[TAB_SHIFT-1:0];
    if (xe <= RATIO_LO) begin
      r = 23'(RATIO_TAB[0]) + 23'(RATIO_LO - xe);
    end else if (xe >= RATIO_HI) begin
      r = '0;
    end else begin
      a    = RATIO_TAB[i];
      b    = RATIO_TAB[i + 6'd1];
      prod = 33'(a - b) * 33'(fr);
      r    = 23'(a - 19'(prod >> TAB_SHIFT));
    end
    return r;
  endfunction

endpackage

[design/tsr_iter_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tsr_iter_unit
// Shared restoring divider and integer square root, one digit per cycle
// ---------------------------------------------------------------------------
module tsr_iter_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tsr_pkg::unit_req_t         req_i,
  output logic                       done_o,
  output logic [tsr_pkg::OPA_W-1:0]  result_o
);
  import tsr_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  unit_mode_e       mode_q, mode_d;
  logic [5:0]       cnt_q, cnt_d;
  logic [35:0]      rem_q, rem_d;
  logic [OPA_W-1:0] acc_q, acc_d;
  logic [OPA_W-1:0] src_q, src_d;
  logic [OPB_W-1:0] den_q, den_d;

  logic [37:0] shv;
  logic [37:0] sub;
  logic        ge;
  logic [37:0] diff;

  // trial subtract: divisor for divide, 4*root+1 for square root
  always_comb begin
    if (mode_q == MODE_SQRT) begin
      shv = {rem_q, src_q[OPA_W-1:OPA_W-2]};
      sub = {8'b0, acc_q[27:0], 2'b01};
    end else begin
      shv = {1'b0, rem_q, src_q[OPA_W-1]};
      sub = {4'b0, den_q};
    end
    ge   = (shv >= sub);
    diff = shv - sub;
  end

  // iteration control
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    mode_d = mode_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    acc_d  = acc_q;
    src_d  = src_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      mode_d = req_i.mode;
      cnt_d  = (req_i.mode == MODE_SQRT) ? 6'(SQRT_STEPS - 1) : 6'(DIV_STEPS - 1);
      rem_d  = '0;
      acc_d  = '0;
      src_d  = req_i.opa;
      den_d  = req_i.opb;
    end else if (busy_q) begin
      rem_d = ge ? diff[35:0] : shv[35:0];
      acc_d = {acc_q[OPA_W-2:0], ge};
      src_d = (mode_q == MODE_SQRT) ? {src_q[OPA_W-3:0], 2'b00} : {src_q[OPA_W-2:0], 1'b0};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // operand and partial result registers
  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    cnt_q  <= cnt_d;
    rem_q  <= rem_d;
    acc_q  <= acc_d;
    src_q  <= src_d;
    den_q  <= den_d;
  end

  assign done_o   = done_q;
  assign result_o = acc_q;

endmodule

[design/tsr_store.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tsr_store
// Player memory with registered read and a clearing pass over all entries
// ---------------------------------------------------------------------------
module tsr_store #(
  parameter int unsigned PLAYERS = tsr_pkg::DEF_PLAYERS,
  parameter int unsigned IDX_W   = (PLAYERS > 1) ? $clog2(PLAYERS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] rd_addr_i,
  output tsr_pkg::entry_t  rd_data_o,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  tsr_pkg::entry_t  wr_data_i,
  input  logic             clr_req_i,
  output logic             clearing_o
);
  import tsr_pkg::*;

  entry_t mem [PLAYERS];

  logic             clr_q, clr_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             we;
  logic [IDX_W-1:0] wa;
  entry_t           wd;
  entry_t           rd_q;

  // clearing pass sequencing, starts after reset and on a clear request
  always_comb begin
    clr_d = clr_q;
    cnt_d = cnt_q;
    if (clr_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == IDX_W'(PLAYERS - 1)) begin
        clr_d = 1'b0;
        cnt_d = '0;
      end
    end else if (clr_req_i) begin
      clr_d = 1'b1;
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= 1'b1;
      cnt_q <= '0;
    end else begin
      clr_q <= clr_d;
      cnt_q <= cnt_d;
    end
  end

  // write port shared by the clearing pass and the sequencer
  always_comb begin
    we = clr_q | wr_en_i;
    wa = clr_q ? cnt_q : wr_addr_i;
    wd = clr_q ? '0 : wr_data_i;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[rd_addr_i];
  end

  assign rd_data_o  = rd_q;
  assign clearing_o = clr_q;

endmodule

[design/two_player_skill_rating_update.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// two_player_skill_rating_update
// Two-player rating update: win probability, mean and variance per player
// ---------------------------------------------------------------------------
// channel   ports                                      handshake
// request   operation_i black_player_i white_player_i  start & !busy
//           black_won_i
// result    black_win_probability_o black_mean_o       result_valid_o, 1 cycle
//           black_spread_o white_mean_o white_spread_o
// config    cfg_idx_i cfg_data_i                       cfg_we_i
//
// predict and add game run on the shared divide / square root unit
// (56 steps per divide, 28 per root, 1 per cycle).
// clear runs the predict sequence, then a pass over all PLAYERS store entries.
// after reset the same clearing pass runs, with busy high.
// results are presented for one cycle; the receiver cannot stall.
module two_player_skill_rating_update #(
  parameter int unsigned PLAYERS = tsr_pkg::DEF_PLAYERS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation_i,
  input  logic [9:0]         black_player_i,
  input  logic [9:0]         white_player_i,
  input  logic               black_won_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [22:0]        cfg_data_i,
  output logic               result_valid_o,
  output logic [16:0]        black_win_probability_o,
  output logic signed [31:0] black_mean_o,
  output logic [30:0]        black_spread_o,
  output logic signed [31:0] white_mean_o,
  output logic [30:0]        white_spread_o
);
  import tsr_pkg::*;

  localparam int unsigned IDX_W = (PLAYERS > 1) ? $clog2(PLAYERS) : 1;

  // entry read with invalid default and variance floor
  function automatic entry_t fetch(input entry_t e, input logic [22:0] iv);
    entry_t r;
    r.valid = 1'b1;
    if (e.valid) begin
      r.mean   = e.mean;
      r.spread = (e.spread == '0) ? 31'd1 : e.spread;
    end else begin
      r.mean   = '0;
      r.spread = (iv == '0) ? 31'd1 : 31'(iv);
    end
    return r;
  endfunction

  // configuration registers
  logic [22:0] beta_q, init_q, added_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_q  <= 23'd65536;
      init_q  <= 23'd45875;
      added_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BETA_SQ:  beta_q  <= cfg_data_i;
        CFG_INIT_VAR: init_q  <= cfg_data_i;
        CFG_ADD_VAR:  added_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;

  // request and working registers
  logic [1:0]         op_q;
  logic [IDX_W-1:0]   bidx_q, widx_q;
  logic               bwon_q;
  logic signed [31:0] mb_q, mw_q;
  logic [30:0]        vb_q, vw_q;
  logic [16:0]        prob_q;
  logic [OPB_W-1:0]   c2_q;
  logic [24:0]        c_q;
  logic signed [23:0] x_q;
  logic [22:0]        v_q;
  logic [16:0]        w_q;
  logic               side_q;
  logic signed [31:0] mnew_q [2];
  logic [30:0]        vnew_q [2];
  logic [OPA_W-1:0]   mul_q;

  // output registers
  logic               rv_q;
  logic [16:0]        out_prob_q;
  logic signed [31:0] out_bm_q, out_wm_q;
  logic [30:0]        out_bs_q, out_ws_q;

  // unit and store connections
  unit_req_t          ureq;
  logic               udone;
  logic [OPA_W-1:0]   ures;
  logic [IDX_W-1:0]   rd_addr, wr_addr;
  entry_t             rd_data, wr_data, fe;
  logic               mem_we, clr_req, clearing;

  // winner / loser view of the fetched players
  logic signed [31:0] mwin, mlos, m_side;
  logic [31:0]        vwin_s, vlos_s;
  logic [30:0]        vwin, vlos, var_side;
  logic signed [32:0] diff_p, diff_g;
  logic [32:0]        mag_p, mag_g;
  logic [OPB_W-1:0]   c2p, c2g;
  logic [22:0]        qcap;
  logic               same;

  // shrink operands
  logic [22:0]        vc;
  logic signed [24:0] xs, s_sum;
  logic [23:0]        s_cl;

  // multiplier
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod;

  // mean update
  logic signed [34:0] m_ext, m_sum, q_ext;
  logic signed [31:0] m_sat;
  logic [16:0]        f_cap;
  logic [39:0]        r_var;

  assign fe = fetch(rd_data, init_q);

  always_comb begin
    mwin   = bwon_q ? mb_q : mw_q;
    mlos   = bwon_q ? mw_q : mb_q;
    vwin_s = 32'(bwon_q ? vb_q : vw_q) + 32'(added_q);
    vlos_s = 32'(bwon_q ? vw_q : vb_q) + 32'(added_q);
    vwin   = vwin_s[31] ? VAR_MAX : vwin_s[30:0];
    vlos   = vlos_s[31] ? VAR_MAX : vlos_s[30:0];
    m_side   = side_q ? mlos : mwin;
    var_side = side_q ? vlos : vwin;
    diff_p = 33'(mb_q) - 33'(mw_q);
    diff_g = 33'(mwin) - 33'(mlos);
    mag_p  = diff_p[32] ? 33'(-diff_p) : 33'(diff_p);
    mag_g  = diff_g[32] ? 33'(-diff_g) : 33'(diff_g);
    c2p    = (OPB_W'(beta_q) << 1) + OPB_W'(vb_q) + OPB_W'(vw_q);
    c2g    = (OPB_W'(beta_q) << 1) + OPB_W'(vwin) + OPB_W'(vlos);
    qcap   = ((|ures[OPA_W-1:23]) || (ures[22:0] > DELTA_CAP)) ? DELTA_CAP : ures[22:0];
    same   = (bidx_q == widx_q);
  end

  // w = v*(v+x), with the deep-upset case pinned at x = -5
  always_comb begin
    if ($signed({x_q[23], x_q}) < RATIO_LO) begin
      xs = RATIO_LO;
      vc = 23'(RATIO_TAB[0]);
    end else begin
      xs = {x_q[23], x_q};
      vc = v_q;
    end
    s_sum = 25'(vc) + xs;
    s_cl  = s_sum[24] ? '0 : s_sum[23:0];
  end

  // mean plus or minus the scaled quotient, saturated to 32 bits
  always_comb begin
    m_ext = 35'(m_side);
    q_ext = $signed({2'b00, ures[32:0]});
    m_sum = side_q ? (m_ext - q_ext) : (m_ext + q_ext);
    if (|ures[OPA_W-1:33]) begin
      m_sat = side_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if (m_sum > 35'sh0_7FFF_FFFF) begin
      m_sat = 32'sh7FFF_FFFF;
    end else if (m_sum < -35'sh0_8000_0000) begin
      m_sat = 32'sh8000_0000;
    end else begin
      m_sat = m_sum[31:0];
    end
    f_cap = ((|ures[OPA_W-1:17]) || (ures[16:0] > Q_ONE)) ? Q_ONE : ures[16:0];
    r_var = mul_q[OPA_W-1:FRAC_BITS];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (start && !busy) state_d = ST_RD_B;
      ST_RD_B:    state_d = ST_RD_W;
      ST_RD_W:    state_d = ST_FETCH;
      ST_FETCH:   state_d = ST_PR_GO;
      ST_PR_GO:   state_d = ST_PR_WT;
      ST_PR_WT:   if (udone) state_d = ST_PD_GO;
      ST_PD_GO:   state_d = ST_PD_WT;
      ST_PD_WT:   if (udone) state_d = ST_PROB;
      ST_PROB:    state_d = (op_q == OP_GAME) ? ST_GR_GO : ST_DONE;
      ST_GR_GO:   state_d = ST_GR_WT;
      ST_GR_WT:   if (udone) state_d = ST_GX_GO;
      ST_GX_GO:   state_d = ST_GX_WT;
      ST_GX_WT:   if (udone) state_d = ST_GV;
      ST_GV:      state_d = ST_GRATIO;
      ST_GRATIO:  state_d = ST_GWM;
      ST_GWM:     state_d = ST_GWC;
      ST_GWC:     state_d = ST_MM;
      ST_MM:      state_d = ST_MD_GO;
      ST_MD_GO:   state_d = ST_MD_WT;
      ST_MD_WT:   if (udone) state_d = ST_MS;
      ST_MS:      state_d = ST_VM;
      ST_VM:      state_d = ST_VD_GO;
      ST_VD_GO:   state_d = ST_VD_WT;
      ST_VD_WT:   if (udone) state_d = ST_VF;
      ST_VF:      state_d = ST_VS;
      ST_VS:      state_d = side_q ? ST_WR_WIN : ST_MM;
      ST_WR_WIN:  state_d = ST_WR_LOS;
      ST_WR_LOS:  state_d = ST_DONE;
      ST_DONE:    state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs: unit requests, multiplier operands, store access
  always_comb begin
    ureq       = '0;
    ureq.mode  = MODE_DIV;
    mul_a      = '0;
    mul_b      = '0;
    rd_addr    = bidx_q;
    mem_we     = 1'b0;
    wr_addr    = bwon_q ? bidx_q : widx_q;
    wr_data    = {1'b1, mnew_q[0], vnew_q[0]};
    clr_req    = 1'b0;
    unique case (state_q)
      ST_RD_B: rd_addr = bidx_q;
      ST_RD_W: rd_addr = widx_q;
      ST_PR_GO: begin
        ureq.start = 1'b1;
        ureq.mode  = MODE_SQRT;
        ureq.opa   = OPA_W'({c2p, 16'b0});
      end
      ST_PD_GO: begin
        ureq.start = 1'b1;
        ureq.opa   = OPA_W'({mag_p, 16'b0});
        ureq.opb   = OPB_W'(ures[24:0]);
      end
      ST_GR_GO: begin
        ureq.start = 1'b1;
        ureq.mode  = MODE_SQRT;
        ureq.opa   = OPA_W'({c2_q, 16'b0});
      end
      ST_GX_GO: begin
        ureq.start = 1'b1;
        ureq.opa   = OPA_W'({mag_g, 16'b0});
        ureq.opb   = OPB_W'(ures[24:0]);
      end
      ST_GWM: begin
        mul_a = 32'(vc);
        mul_b = 32'(s_cl);
      end
      ST_MM: begin
        mul_a = 32'(var_side);
        mul_b = 32'(v_q);
      end
      ST_MD_GO: begin
        ureq.start = 1'b1;
        ureq.opa   = mul_q;
        ureq.opb   = OPB_W'(c_q);
      end
      ST_VM: begin
        mul_a = 32'(var_side);
        mul_b = 32'(w_q);
      end
      ST_VD_GO: begin
        ureq.start = 1'b1;
        ureq.opa   = mul_q;
        ureq.opb   = c2_q;
      end
      ST_VF: begin
        mul_a = 32'(var_side);
        mul_b = 32'(Q_ONE - f_cap);
      end
      ST_WR_WIN: mem_we = 1'b1;
      ST_WR_LOS: begin
        mem_we  = 1'b1;
        wr_addr = bwon_q ? widx_q : bidx_q;
        wr_data = {1'b1, mnew_q[1], vnew_q[1]};
      end
      ST_DONE: clr_req = (op_q == OP_CLEAR);
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  // state and strobe registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rv_q    <= (state_q == ST_DONE);
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        op_q   <= operation_i;
        bidx_q <= IDX_W'(idx_mod(black_player_i, PLAYERS));
        widx_q <= IDX_W'(idx_mod(white_player_i, PLAYERS));
        bwon_q <= black_won_i;
      end
      ST_RD_W: begin
        mb_q <= fe.mean;
        vb_q <= fe.spread;
      end
      ST_FETCH: begin
        mw_q <= fe.mean;
        vw_q <= fe.spread;
      end
      ST_PROB: begin
        prob_q <= (diff_p[32] && qcap != '0) ? (PROB_ONE - phi_q16(qcap)) : phi_q16(qcap);
        c2_q   <= c2g;
      end
      ST_GX_GO: c_q <= ures[24:0];
      ST_GV:    x_q <= (diff_g[32] && qcap != '0) ? -$signed({1'b0, qcap}) : $signed({1'b0, qcap});
      ST_GRATIO: v_q <= gauss_ratio(x_q);
      ST_GWM, ST_MM, ST_VM, ST_VF: mul_q <= prod[OPA_W-1:0];
      ST_GWC: begin
        w_q    <= (r_var > 40'(Q_ONE)) ? Q_ONE : r_var[16:0];
        side_q <= 1'b0;
      end
      ST_MS: mnew_q[side_q] <= m_sat;
      ST_VS: begin
        vnew_q[side_q] <= (r_var == '0) ? 31'd1 : r_var[30:0];
        side_q         <= 1'b1;
      end
      default: ;
    endcase
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE) begin
      out_prob_q <= prob_q;
      priority if (op_q == OP_CLEAR) begin
        out_bm_q <= '0;
        out_wm_q <= '0;
        out_bs_q <= (init_q == '0) ? 31'd1 : 31'(init_q);
        out_ws_q <= (init_q == '0) ? 31'd1 : 31'(init_q);
      end else if (op_q == OP_GAME) begin
        out_bm_q <= (!bwon_q || same) ? mnew_q[1] : mnew_q[0];
        out_bs_q <= (!bwon_q || same) ? vnew_q[1] : vnew_q[0];
        out_wm_q <= (bwon_q || same) ? mnew_q[1] : mnew_q[0];
        out_ws_q <= (bwon_q || same) ? vnew_q[1] : vnew_q[0];
      end else begin
        out_bm_q <= mb_q;
        out_bs_q <= vb_q;
        out_wm_q <= mw_q;
        out_ws_q <= vw_q;
      end
    end
  end

  tsr_iter_unit u_unit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (ureq),
    .done_o   (udone),
    .result_o (ures)
  );

  tsr_store #(
    .PLAYERS (PLAYERS),
    .IDX_W   (IDX_W)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data),
    .wr_en_i    (mem_we),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .clr_req_i  (clr_req),
    .clearing_o (clearing)
  );

  assign busy                    = (state_q != ST_IDLE) || clearing;
  assign result_valid_o          = rv_q;
  assign black_win_probability_o = out_prob_q;
  assign black_mean_o            = out_bm_q;
  assign black_spread_o          = out_bs_q;
  assign white_mean_o            = out_wm_q;
  assign white_spread_o          = out_ws_q;

  // one result per request, never back to back
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  // an accepted request starts the read sequence
  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == ST_RD_B))
    else $error("accepted request did not start the sequencer");

  // sequencer never writes the store during a clearing pass
  a_no_write_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(clearing && mem_we))
    else $error("store write during clearing pass");

  // the shared unit finishes only while the sequencer waits for it
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    udone |-> (state_q == ST_PR_WT || state_q == ST_PD_WT || state_q == ST_GR_WT ||
               state_q == ST_GX_WT || state_q == ST_MD_WT || state_q == ST_VD_WT))
    else $error("unit result arrived outside a wait state");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench of the two-player rating update
// ---------------------------------------------------------------------------
// A rating scoreboard class holds its own copy of the player store and of the
// registers. It works out the win probability and the stored ratings each
// request should return and compares them with every result strobe. Directed
// requests cover the field extremes, all operations and the special cases.
// Random phases then follow, each under its own register setting, mostly games
// within a small pool of players.
// ---------------------------------------------------------------------------
module tb_top;

  import tsr_pkg::*;

  localparam logic [1:0]  OP_SPARE   = 2'd3;
  localparam int          PHASES     = 5;
  localparam int          PER_PHASE  = 140;
  localparam int unsigned CYCLE_CAP  = 3000000;
  localparam longint      Q1         = 64'd65536;
  localparam longint      GAP_CAP    = 64'd64 << FRAC_BITS;
  localparam longint      RATIO_EDGE = 64'd5 << FRAC_BITS;
  localparam longint      SPREAD_TOP = 64'h7FFF_FFFF;

  // expected contents of one result
  typedef struct {
    logic [16:0]        prob;
    logic signed [31:0] b_mean;
    logic [30:0]        b_spread;
    logic signed [31:0] w_mean;
    logic [30:0]        w_spread;
  } rating_result_t;

  // player store copy, rating math and result queue
  class rating_scoreboard;
    bit             known [1024];
    longint         mean_of [1024];
    longint         spread_of [1024];
    longint         beta_sq;
    longint         init_var;
    longint         add_var;
    rating_result_t awaited [$];
    int             errors;

    function new();
      foreach (known[i]) known[i] = 1'b0;
      beta_sq  = 65536;
      init_var = 45875;
      add_var  = 0;
      errors   = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [22:0] val);
      case (idx)
        CFG_BETA_SQ:  beta_sq  = val;
        CFG_INIT_VAR: init_var = val;
        CFG_ADD_VAR:  add_var  = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void read_player(int i, output longint m, output longint s);
      if (known[i]) begin
        m = mean_of[i];
        s = spread_of[i];
      end else begin
        m = 0;
        s = init_var;
      end
      if (s < 1) s = 1;
      if (s > SPREAD_TOP) s = SPREAD_TOP;
    endfunction

    function longint root_q(longint c2);
      longint unsigned n;
      longint unsigned r;
      longint unsigned b;
      n = longint'(c2) << FRAC_BITS;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return longint'(r);
    endfunction

    // signed mean gap over c, truncated and capped
    function longint norm_gap(longint ma, longint mb, longint c);
      longint d;
      longint mag;
      longint q;
      d   = ma - mb;
      mag = (d < 0) ? -d : d;
      q   = (mag << FRAC_BITS) / c;
      if (q > GAP_CAP) q = GAP_CAP;
      return (d < 0) ? -q : q;
    endfunction

    function longint win_prob(longint x);
      longint mag;
      longint i;
      longint fr;
      longint p;
      mag = (x < 0) ? -x : x;
      i   = mag >> TAB_SHIFT;
      fr  = mag & ((64'd1 << TAB_SHIFT) - 1);
      if (i >= 20) p = Q1;
      else p = PHI_TAB[i] + (((PHI_TAB[i+1] - PHI_TAB[i]) * fr) >> TAB_SHIFT);
      return (x < 0) ? Q1 - p : p;
    endfunction

    // N/Phi lookup with linear tail below the table
    function longint surprise(longint x);
      longint u;
      longint i;
      longint fr;
      if (x <= -RATIO_EDGE) return longint'(RATIO_TAB[0]) + (-RATIO_EDGE - x);
      if (x >= RATIO_EDGE) return 0;
      u  = x + RATIO_EDGE;
      i  = u >> TAB_SHIFT;
      fr = u & ((64'd1 << TAB_SHIFT) - 1);
      return RATIO_TAB[i] - (((RATIO_TAB[i] - RATIO_TAB[i+1]) * fr) >> TAB_SHIFT);
    endfunction

    function longint shrink_factor(longint x, longint v);
      longint vc;
      longint s;
      longint w;
      vc = v;
      if (x < -RATIO_EDGE) begin
        x  = -RATIO_EDGE;
        vc = RATIO_TAB[0];
      end
      s = vc + x;
      if (s < 0) s = 0;
      w = (vc * s) >> FRAC_BITS;
      return (w > Q1) ? Q1 : w;
    endfunction

    function longint shrunk_spread(longint sp, longint w, longint c2);
      longint f;
      longint r;
      f = (sp * w) / c2;
      if (f > Q1) f = Q1;
      r = (sp * (Q1 - f)) >> FRAC_BITS;
      return (r < 1) ? 1 : r;
    endfunction

    function longint clip_mean(longint m);
      if (m > 64'sd2147483647) return 64'sd2147483647;
      if (m < -64'sd2147483648) return -64'sd2147483648;
      return m;
    endfunction

    // work out the result of one accepted request and update the store
    function void note_request(logic [1:0] op, logic [9:0] bp, logic [9:0] wp,
                               logic won);
      rating_result_t e;
      longint mb, mw, vb, vw, mwin, mlos, vwin, vlos, c2, c, x, v, w;
      int wi, li;
      read_player(bp, mb, vb);
      read_player(wp, mw, vw);
      e.prob = 17'(win_prob(norm_gap(mb, mw, root_q(2 * beta_sq + vb + vw))));
      if (op == OP_CLEAR) begin
        foreach (known[i]) known[i] = 1'b0;
      end else if (op == OP_GAME) begin
        wi   = won ? bp : wp;
        li   = won ? wp : bp;
        mwin = won ? mb : mw;
        mlos = won ? mw : mb;
        vwin = (won ? vb : vw) + add_var;
        vlos = (won ? vw : vb) + add_var;
        if (vwin > SPREAD_TOP) vwin = SPREAD_TOP;
        if (vlos > SPREAD_TOP) vlos = SPREAD_TOP;
        c2 = 2 * beta_sq + vwin + vlos;
        c  = root_q(c2);
        x  = norm_gap(mwin, mlos, c);
        v  = surprise(x);
        w  = shrink_factor(x, v);
        // winner first, so a self game keeps the loser values
        mean_of[wi]   = clip_mean(mwin + (vwin * v) / c);
        spread_of[wi] = shrunk_spread(vwin, w, c2);
        known[wi]     = 1'b1;
        mean_of[li]   = clip_mean(mlos - (vlos * v) / c);
        spread_of[li] = shrunk_spread(vlos, w, c2);
        known[li]     = 1'b1;
      end
      read_player(bp, mb, vb);
      read_player(wp, mw, vw);
      e.b_mean   = 32'(mb);
      e.b_spread = 31'(vb);
      e.w_mean   = 32'(mw);
      e.w_spread = 31'(vw);
      awaited.push_back(e);
    endfunction

    function void check_result(logic [16:0] prob, logic signed [31:0] bm,
                               logic [30:0] bs, logic signed [31:0] wm,
                               logic [30:0] ws);
      rating_result_t e;
      if (awaited.size() == 0) begin
        $error("result strobe with no request outstanding");
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (prob !== e.prob) begin
        $error("black_win_probability expected %0d got %0d", e.prob, prob);
        errors++;
      end
      if (bm !== e.b_mean) begin
        $error("black_mean expected %0d got %0d", e.b_mean, bm);
        errors++;
      end
      if (bs !== e.b_spread) begin
        $error("black_spread expected %0d got %0d", e.b_spread, bs);
        errors++;
      end
      if (wm !== e.w_mean) begin
        $error("white_mean expected %0d got %0d", e.w_mean, wm);
        errors++;
      end
      if (ws !== e.w_spread) begin
        $error("white_spread expected %0d got %0d", e.w_spread, ws);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         operation_i = OP_PREDICT;
  logic [9:0]         black_player_i = '0;
  logic [9:0]         white_player_i = '0;
  logic               black_won_i = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = CFG_BETA_SQ;
  logic [22:0]        cfg_data_i = '0;
  logic               result_valid_o;
  logic [16:0]        black_win_probability_o;
  logic signed [31:0] black_mean_o;
  logic [30:0]        black_spread_o;
  logic signed [31:0] white_mean_o;
  logic [30:0]        white_spread_o;

  rating_scoreboard sb = new();
  int unsigned      cycles = 0;
  logic [9:0]       pool [6];

  two_player_skill_rating_update DUT (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .start                  (start),
    .busy                   (busy),
    .operation_i            (operation_i),
    .black_player_i         (black_player_i),
    .white_player_i         (white_player_i),
    .black_won_i            (black_won_i),
    .cfg_we_i               (cfg_we_i),
    .cfg_idx_i              (cfg_idx_i),
    .cfg_data_i             (cfg_data_i),
    .result_valid_o         (result_valid_o),
    .black_win_probability_o(black_win_probability_o),
    .black_mean_o           (black_mean_o),
    .black_spread_o         (black_spread_o),
    .white_mean_o           (white_mean_o),
    .white_spread_o         (white_spread_o)
  );

  always #5 clk_i = ~clk_i;

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      sb.check_result(black_win_probability_o, black_mean_o, black_spread_o,
                      white_mean_o, white_spread_o);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // write all three registers, enable held high across the burst
  task automatic write_regs(input logic [22:0] beta, input logic [22:0] ivar,
                            input logic [22:0] avar);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_BETA_SQ;
    cfg_data_i <= beta;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_INIT_VAR;
    cfg_data_i <= ivar;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_ADD_VAR;
    cfg_data_i <= avar;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_reg(CFG_BETA_SQ, beta);
    sb.set_reg(CFG_INIT_VAR, ivar);
    sb.set_reg(CFG_ADD_VAR, avar);
  endtask

  // present one request and hold it until accepted
  task automatic issue_request(input logic [1:0] op, input logic [9:0] bp,
                               input logic [9:0] wp, input logic won);
    operation_i    <= op;
    black_player_i <= bp;
    white_player_i <= wp;
    black_won_i    <= won;
    start          <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_request(op, bp, wp, won);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0 || busy) @(posedge clk_i);
  endtask

  // random request: mostly pool games, some predicts, rare clears, noise
  task automatic random_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)
      issue_request(OP_GAME, pool[$urandom_range(0, 5)], pool[$urandom_range(0, 5)],
                    1'($urandom_range(0, 1)));
    else if (r < 82)
      issue_request(OP_PREDICT, pool[$urandom_range(0, 5)], pool[$urandom_range(0, 5)],
                    1'($urandom_range(0, 1)));
    else if (r < 83)
      issue_request(OP_CLEAR, 10'($urandom), 10'($urandom), 1'($urandom_range(0, 1)));
    else if (r < 86)
      issue_request(OP_SPARE, pool[$urandom_range(0, 5)], 10'($urandom),
                    1'($urandom_range(0, 1)));
    else
      issue_request(2'($urandom_range(0, 1)), 10'($urandom), 10'($urandom),
                    1'($urandom_range(0, 1)));
  endtask

  initial begin
    logic [22:0] beta;
    logic [22:0] ivar;
    logic [22:0] avar;
    // reset, then wait out the clearing pass
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    write_regs(23'd65536, 23'd45875, 23'd0);

    // directed: field extremes, every operation, self game, upsets, clear
    issue_request(OP_PREDICT, 10'd0, 10'd1023, 1'b0);
    issue_request(OP_GAME, 10'd0, 10'd1023, 1'b1);
    issue_request(OP_GAME, 10'd0, 10'd1023, 1'b0);
    issue_request(OP_GAME, 10'd5, 10'd5, 1'b1);
    issue_request(OP_SPARE, 10'd1023, 10'd0, 1'b1);
    for (int k = 0; k < 8; k++) issue_request(OP_GAME, 10'd1, 10'd2, 1'b1);
    issue_request(OP_PREDICT, 10'd1, 10'd2, 1'b0);
    issue_request(OP_GAME, 10'd1, 10'd2, 1'b0);
    issue_request(OP_GAME, 10'd2, 10'd1, 1'b1);
    issue_request(OP_CLEAR, 10'd1, 10'd2, 1'b0);
    issue_request(OP_PREDICT, 10'd1, 10'd2, 1'b1);
    issue_request(OP_GAME, 10'd1023, 10'd1023, 1'b0);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin beta = 23'd65536;   ivar = 23'd45875;   avar = 23'd0;       end
        1: begin beta = 23'd1;       ivar = 23'd1;       avar = 23'd0;       end
        2: begin beta = 23'd4194304; ivar = 23'd4194304; avar = 23'd4194304; end
        3: begin
          beta = 23'($urandom_range(1, 4194304));
          ivar = 23'($urandom_range(1, 4194304));
          avar = 23'($urandom_range(0, 4194304));
        end
        default: begin beta = 23'd1; ivar = 23'd4194304; avar = 23'd4194304; end
      endcase
      write_regs(beta, ivar, avar);
      foreach (pool[i]) pool[i] = 10'($urandom);
      pool[0] = 10'd0;
      pool[1] = 10'd1023;
      for (int n = 0; n < PER_PHASE; n++) begin
        random_request();
        // sender gaps, none in the last phase
        if (ph < PHASES - 1 && $urandom_range(0, 3) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk_i);
        end
      end
      // hold off until every result is back
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
